FILE: design/svv_pkg.sv
// ----------------------------------------------------------------------------
// svv_pkg: shared types and constants for the version string validator
// Character codes, verdict codes, section encoding and the item/verdict
// structs passed between the input stage, the scanner and the top level.
// ----------------------------------------------------------------------------
package svv_pkg;

  typedef enum logic [1:0] {
    SEC_CORE  = 2'd0,
    SEC_PRE   = 2'd1,
    SEC_BUILD = 2'd2
  } section_t;

  // verdict codes
  localparam logic [3:0] ERR_OK            = 4'd0;
  localparam logic [3:0] ERR_EMPTY         = 4'd1;
  localparam logic [3:0] ERR_ORDER         = 4'd2;
  localparam logic [3:0] ERR_BUILD_EMPTY   = 4'd3;
  localparam logic [3:0] ERR_BUILD_LONG    = 4'd4;
  localparam logic [3:0] ERR_BUILD_BAD     = 4'd5;
  localparam logic [3:0] ERR_PRE_EMPTY     = 4'd6;
  localparam logic [3:0] ERR_PRE_LONG      = 4'd7;
  localparam logic [3:0] ERR_PRE_BAD       = 4'd8;
  localparam logic [3:0] ERR_CORE_LONG     = 4'd9;
  localparam logic [3:0] ERR_CORE_DOTS     = 4'd10;
  localparam logic [3:0] ERR_CORE_MISSING  = 4'd11;
  localparam logic [3:0] ERR_CORE_NONDIGIT = 4'd12;
  localparam logic [3:0] ERR_CORE_LEADZERO = 4'd13;
  localparam logic [3:0] ERR_CORE_RANGE    = 4'd14;

  // character codes
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LOWER_V = 8'h76;
  localparam logic [7:0] CH_UPPER_V = 8'h56;

  localparam logic [20:0] VALUE_LIMIT = 21'd1000000;

  typedef struct packed {
    logic       is_last;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic        has_meta;
    logic        has_pre;
    logic [19:0] patch_value;
    logic [19:0] minor_value;
    logic [19:0] major_value;
    logic [3:0]  error_code;
    logic        ok;
  } result_t;

endpackage

FILE: design/svv_in_reg.sv
// ----------------------------------------------------------------------------
// svv_in_reg: input register
// Holds one accepted byte until the scanner consumes it; refills in the
// same cycle the held item moves on.
// ----------------------------------------------------------------------------
module svv_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // [7:0] char_byte
  input  logic           s_tlast,   // is_last
  input  logic           advance,
  output logic           p_valid,
  output svv_pkg::item_t p_item
);
  import svv_pkg::*;

  assign s_tready = !p_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      p_item.char_byte <= s_tdata;
      p_item.is_last   <= s_tlast;
    end
  end

endmodule

FILE: design/svv_scan.sv
// ----------------------------------------------------------------------------
// svv_scan: running parse state and verdict logic
// Updates the section, part and segment trackers for one byte per cycle while
// step_en is high, and forms the verdict for a byte that ends the string.
// ----------------------------------------------------------------------------
module svv_scan #(
  parameter int MAX_SECTION_LEN = 256,
  parameter int MAX_SEGMENT_LEN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  svv_pkg::item_t   item,
  output svv_pkg::result_t res
);
  import svv_pkg::*;

  localparam int SECL_W = $clog2(MAX_SECTION_LEN + 1);
  localparam int SEGL_W = $clog2(MAX_SEGMENT_LEN + 1);
  localparam logic [SECL_W-1:0] SEC_MAX = SECL_W'(MAX_SECTION_LEN);
  localparam logic [SEGL_W-1:0] SEG_MAX = SEGL_W'(MAX_SEGMENT_LEN);

  typedef struct packed {
    section_t          section;
    logic              first;
    logic              dash;
    logic [SECL_W-1:0] sec_len;
    logic [1:0]        dots;
    logic [1:0]        pidx;
    logic [20:0]       acc;
    logic              pf_ne;
    logic              pf_nd;
    logic              pf_lz;
    logic              pf_ov;
    logic [SEGL_W-1:0] seg_len;
    logic              sf_nd;
    logic              sf_fz;
    logic [19:0]       pv0;
    logic [19:0]       pv1;
    logic [19:0]       pv2;
    logic [3:0]        e_core;
    logic [3:0]        e_pre;
    logic [3:0]        e_build;
    logic              order_err;
  } st_t;

  st_t st, st_next;

  function automatic st_t st_reset();
    st_t s;
    s         = '0;
    s.section = SEC_CORE;
    s.first   = 1'b1;
    return s;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_DASH;
  endfunction

  function automatic st_t set_err(st_t s, logic is_pre, logic [3:0] e);
    if (is_pre) s.e_pre = e;
    else s.e_build = e;
    return s;
  endfunction

  function automatic st_t count_byte(st_t s);
    if (s.sec_len < SEC_MAX) s.sec_len = s.sec_len + SECL_W'(1);
    return s;
  endfunction

  function automatic st_t open_section(st_t s, section_t sec);
    s.section = sec;
    s.sec_len = '0;
    s.seg_len = '0;
    s.sf_nd   = 1'b0;
    s.sf_fz   = 1'b0;
    return s;
  endfunction

  function automatic st_t close_part(st_t s);
    logic [3:0] e;
    e = ERR_OK;
    if (s.pf_ne) begin
      if (s.pf_nd) e = ERR_CORE_NONDIGIT;
      else if (s.pf_lz) e = ERR_CORE_LEADZERO;
      else if (s.pf_ov) e = ERR_CORE_RANGE;
      if (e != ERR_OK && s.e_core == ERR_OK) s.e_core = e;
      if (e == ERR_OK) begin
        // acc is at most the limit here, so it fits in 20 bits
        unique case (s.pidx)
          2'd0:    s.pv0 = s.acc[19:0];
          2'd1:    s.pv1 = s.acc[19:0];
          2'd2:    s.pv2 = s.acc[19:0];
          default: ;
        endcase
      end
      if (s.pidx != 2'd3) s.pidx = s.pidx + 2'd1;
    end
    s.acc   = '0;
    s.pf_ne = 1'b0;
    s.pf_nd = 1'b0;
    s.pf_lz = 1'b0;
    s.pf_ov = 1'b0;
    return s;
  endfunction

  function automatic st_t core_byte(st_t s, logic [7:0] c);
    logic [23:0] tmp;
    tmp = '0;
    if (c == CH_DOT) begin
      s = close_part(s);
      if (s.dots != 2'd3) s.dots = s.dots + 2'd1;
    end else begin
      if (!s.pf_ne) s.pf_ne = 1'b1;
      else if (!s.pf_nd && s.acc == '0) s.pf_lz = 1'b1;
      if (is_digit(c)) begin
        if (s.acc <= VALUE_LIMIT) begin
          tmp = ({3'b000, s.acc} << 3) + ({3'b000, s.acc} << 1) + 24'(c - CH_ZERO);
          if (tmp > 24'(VALUE_LIMIT)) begin
            s.acc   = VALUE_LIMIT + 21'd1;
            s.pf_ov = 1'b1;
          end else begin
            s.acc = tmp[20:0];
          end
        end
      end else begin
        s.pf_nd = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic st_t close_core(st_t s);
    s = close_part(s);
    if (s.sec_len >= SEC_MAX) s.e_core = ERR_CORE_LONG;
    else if (s.dots != 2'd2) s.e_core = ERR_CORE_DOTS;
    else if (s.e_core != ERR_OK) s.e_core = s.e_core;
    else if (s.pidx != 2'd3) s.e_core = ERR_CORE_MISSING;
    else s.e_core = ERR_OK;
    return s;
  endfunction

  function automatic st_t close_segment(st_t s, logic is_pre, logic [3:0] bad);
    logic fail;
    fail = s.seg_len == '0 || s.seg_len >= SEG_MAX;
    // numeric prerelease identifier with a leading zero
    if (is_pre && !s.sf_nd && s.sf_fz && s.seg_len > SEGL_W'(1)) fail = 1'b1;
    if (fail) s = set_err(s, is_pre, bad);
    s.seg_len = '0;
    s.sf_nd   = 1'b0;
    s.sf_fz   = 1'b0;
    return s;
  endfunction

  function automatic st_t ident_byte(st_t s, logic is_pre, logic [7:0] c);
    logic [3:0] bad;
    bad = is_pre ? ERR_PRE_BAD : ERR_BUILD_BAD;
    if (c == CH_DOT) begin
      s = close_segment(s, is_pre, bad);
    end else begin
      if (!is_ident(c)) s = set_err(s, is_pre, bad);
      if (s.seg_len == '0 && c == CH_ZERO) s.sf_fz = 1'b1;
      if (!is_digit(c)) s.sf_nd = 1'b1;
      if (s.seg_len < SEG_MAX) s.seg_len = s.seg_len + SEGL_W'(1);
    end
    return s;
  endfunction

  function automatic st_t close_ident(st_t s, logic is_pre);
    logic [3:0] e_empty, e_long, e_bad;
    e_empty = is_pre ? ERR_PRE_EMPTY : ERR_BUILD_EMPTY;
    e_long  = is_pre ? ERR_PRE_LONG  : ERR_BUILD_LONG;
    e_bad   = is_pre ? ERR_PRE_BAD   : ERR_BUILD_BAD;
    s = close_segment(s, is_pre, e_bad);
    if (s.sec_len == '0) s = set_err(s, is_pre, e_empty);
    else if (s.sec_len >= SEC_MAX) s = set_err(s, is_pre, e_long);
    return s;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [3:0] err;
    st_t        n;
    c   = item.char_byte;
    err = ERR_OK;
    n   = st;
    res = '0;
    if (st.first && (c == CH_LOWER_V || c == CH_UPPER_V)) begin
      // prefix byte: a string made of the prefix alone is empty
      n.first = 1'b0;
      if (item.is_last) begin
        res.error_code = ERR_EMPTY;
        n = st_reset();
      end
    end else begin
      n.first = 1'b0;
      unique case (n.section)
        SEC_CORE: begin
          if (c == CH_DASH) begin
            n      = close_core(n);
            n.dash = 1'b1;
            n      = open_section(n, SEC_PRE);
          end else if (c == CH_PLUS) begin
            n = close_core(n);
            n = open_section(n, SEC_BUILD);
          end else begin
            n = count_byte(core_byte(n, c));
          end
        end
        SEC_PRE: begin
          if (c == CH_PLUS) begin
            n = close_ident(n, 1'b1);
            n = open_section(n, SEC_BUILD);
          end else begin
            n = count_byte(ident_byte(n, 1'b1, c));
          end
        end
        default: begin
          if (c == CH_DASH && !n.dash) n.order_err = 1'b1;
          n = count_byte(ident_byte(n, 1'b0, c));
        end
      endcase

      if (item.is_last) begin
        unique case (n.section)
          SEC_CORE: n = close_core(n);
          SEC_PRE:  n = close_ident(n, 1'b1);
          default:  n = close_ident(n, 1'b0);
        endcase
        if (n.order_err) err = ERR_ORDER;
        else if (n.e_build != ERR_OK) err = n.e_build;
        else if (n.e_pre != ERR_OK) err = n.e_pre;
        else err = n.e_core;
        res.ok         = err == ERR_OK;
        res.error_code = err;
        if (err == ERR_OK) begin
          res.major_value = n.pv0;
          res.minor_value = n.pv1;
          res.patch_value = n.pv2;
          res.has_pre     = n.dash;
          res.has_meta    = n.section == SEC_BUILD;
        end
        n = st_reset();
      end
    end
    st_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset();
    end else if (step_en) begin
      st <= st_next;
    end
  end

endmodule

FILE: design/semver_string_validator.sv
// ----------------------------------------------------------------------------
// semver_string_validator: streaming semantic version string checker
// Consumes a version string one byte per item and returns one verdict item
// for the byte marked tlast.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, with no gaps between strings,
// except when stalled as described below: each byte is held in an input
// register and the next parse state is formed from it combinationally (one
// times-ten accumulate and a few compares). The verdict for a string is
// registered on the output when its final byte is consumed and waits there
// until taken; the input keeps flowing while it waits, and stalls only when
// a second final byte reaches the scanner before the first verdict has left.
// No clearing pass follows reset.
module semver_string_validator #(
  parameter int MAX_SECTION_LEN = 256,
  parameter int MAX_SEGMENT_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // ok, error_code[3:0], major_value[19:0],
                                 // minor_value[19:0], patch_value[19:0],
                                 // has_pre, has_meta, zero fill
);
  import svv_pkg::*;

  logic    p_valid;
  item_t   p_item;
  logic    advance;
  result_t scan_res;
  result_t o_res;
  logic    o_valid;

  // a byte that does not end the string never needs the output slot
  assign advance = p_valid && (!p_item.is_last || !o_valid || m_tready);

  svv_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .p_valid  (p_valid),
    .p_item   (p_item)
  );

  svv_scan #(
    .MAX_SECTION_LEN (MAX_SECTION_LEN),
    .MAX_SEGMENT_LEN (MAX_SEGMENT_LEN)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (p_item),
    .res     (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && p_item.is_last) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && p_item.is_last) o_res <= scan_res;
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {5'b00000, o_res};

  a_last_gives_verdict : assert property (@(posedge clk) disable iff (rst)
    advance && p_item.is_last |=> m_tvalid)
    else $error("final byte consumed without a verdict");

  a_ok_matches_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_res.ok == (o_res.error_code == ERR_OK)))
    else $error("ok flag disagrees with error code");

  a_fail_clears_fields : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_res.ok |-> (o_res.major_value == '0 && o_res.minor_value == '0 &&
                               o_res.patch_value == '0 && !o_res.has_pre &&
                               !o_res.has_meta))
    else $error("failed verdict carries values");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (p_valid && p_item.is_last && o_valid && !m_tready))
    else $error("input stalled without a pending verdict");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: version string validator
// Streams version strings into the block one byte per item and checks every
// verdict against a cycle-free model of the parser. Directed strings cover
// the core numbers, prerelease and build rules, every verdict code and the
// length limits. Random well-formed versions, damaged versions and noise
// follow. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import svv_pkg::*;

  localparam int SECTION_MAX  = 256;
  localparam int SEGMENT_MAX  = 64;
  localparam int RANDOM_BYTES = 250;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  semver_string_validator #(
    .MAX_SECTION_LEN(SECTION_MAX),
    .MAX_SEGMENT_LEN(SEGMENT_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  result_t    verdict_q[$];
  logic [7:0] line_buf[$];
  int         mismatches = 0;
  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  string      ident_chars =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";
  string      punct_chars = "0123456789.-+vV";

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  section_t    zone;
  bit          at_start, saw_dash, order_bad;
  int unsigned zone_len, core_dots, parts_done, num_acc, seg_len;
  bit          num_nonempty, num_nondigit, num_leadzero, num_over;
  bit          seg_nondigit, seg_firstzero;
  logic [19:0] core_nums[3];
  logic [3:0]  zone_err[3];

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_ident(logic [7:0] c);
    return is_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_DASH;
  endfunction

  function automatic void clear_scan();
    zone = SEC_CORE;
    at_start = 1'b1;
    saw_dash = 1'b0;
    order_bad = 1'b0;
    zone_len = 0;
    core_dots = 0;
    parts_done = 0;
    num_acc = 0;
    {num_nonempty, num_nondigit, num_leadzero, num_over} = '0;
    seg_len = 0;
    {seg_nondigit, seg_firstzero} = '0;
    for (int i = 0; i < 3; i++) begin
      core_nums[i] = '0;
      zone_err[i] = ERR_OK;
    end
  endfunction

  function automatic void bump_len();
    if (zone_len < SECTION_MAX) zone_len++;
  endfunction

  function automatic void enter_zone(section_t z);
    zone = z;
    zone_len = 0;
    seg_len = 0;
    {seg_nondigit, seg_firstzero} = '0;
  endfunction

  function automatic void finish_number();
    logic [3:0] code;
    if (num_nonempty) begin
      code = ERR_OK;
      if (num_nondigit) code = ERR_CORE_NONDIGIT;
      else if (num_leadzero) code = ERR_CORE_LEADZERO;
      else if (num_over) code = ERR_CORE_RANGE;
      if (code != ERR_OK && zone_err[SEC_CORE] == ERR_OK) zone_err[SEC_CORE] = code;
      if (code == ERR_OK && parts_done < 3) core_nums[parts_done] = num_acc[19:0];
      if (parts_done < 3) parts_done++;
    end
    num_acc = 0;
    {num_nonempty, num_nondigit, num_leadzero, num_over} = '0;
  endfunction

  function automatic void core_char(logic [7:0] c);
    if (c == CH_DOT) begin
      finish_number();
      if (core_dots < 3) core_dots++;
      return;
    end
    // a second char after a leading 0 (nothing accumulated yet) is a lead zero
    if (!num_nonempty) num_nonempty = 1'b1;
    else if (!num_nondigit && num_acc == 0) num_leadzero = 1'b1;
    if (is_digit(c)) begin
      if (num_acc <= VALUE_LIMIT) begin
        num_acc = num_acc * 10 + (c - CH_ZERO);
        if (num_acc > VALUE_LIMIT) begin
          num_acc = VALUE_LIMIT + 1;
          num_over = 1'b1;
        end
      end
    end else begin
      num_nondigit = 1'b1;
    end
  endfunction

  function automatic void finish_core();
    logic [3:0] code;
    finish_number();
    if (zone_len >= SECTION_MAX) code = ERR_CORE_LONG;
    else if (core_dots != 2) code = ERR_CORE_DOTS;
    else if (zone_err[SEC_CORE] != ERR_OK) code = zone_err[SEC_CORE];
    else if (parts_done < 3) code = ERR_CORE_MISSING;
    else code = ERR_OK;
    zone_err[SEC_CORE] = code;
  endfunction

  function automatic void finish_segment(section_t z, logic [3:0] bad);
    bit fail;
    fail = seg_len == 0 || seg_len >= SEGMENT_MAX;
    if (z == SEC_PRE && !seg_nondigit && seg_firstzero && seg_len > 1) fail = 1'b1;
    if (fail) zone_err[z] = bad;
    seg_len = 0;
    {seg_nondigit, seg_firstzero} = '0;
  endfunction

  function automatic void ident_char(section_t z, logic [7:0] c);
    logic [3:0] bad;
    bad = (z == SEC_PRE) ? ERR_PRE_BAD : ERR_BUILD_BAD;
    if (c == CH_DOT) begin
      finish_segment(z, bad);
      return;
    end
    if (!is_ident(c)) zone_err[z] = bad;
    if (seg_len == 0 && c == CH_ZERO) seg_firstzero = 1'b1;
    if (!is_digit(c)) seg_nondigit = 1'b1;
    if (seg_len < SEGMENT_MAX) seg_len++;
  endfunction

  function automatic void finish_ident(section_t z);
    bit pre;
    pre = z == SEC_PRE;
    finish_segment(z, pre ? ERR_PRE_BAD : ERR_BUILD_BAD);
    if (zone_len == 0) zone_err[z] = pre ? ERR_PRE_EMPTY : ERR_BUILD_EMPTY;
    else if (zone_len >= SECTION_MAX) zone_err[z] = pre ? ERR_PRE_LONG : ERR_BUILD_LONG;
  endfunction

  // Returns 1 when the byte closes a string; v then holds the verdict.
  function automatic bit predict_byte(input logic [7:0] c, input logic last,
                                      output result_t v);
    logic [3:0] code;
    v = '0;
    if (at_start) begin
      at_start = 1'b0;
      if (c == CH_LOWER_V || c == CH_UPPER_V) begin
        if (!last) return 1'b0;
        v.error_code = ERR_EMPTY;
        clear_scan();
        return 1'b1;
      end
    end
    case (zone)
      SEC_CORE: begin
        if (c == CH_DASH) begin
          finish_core();
          saw_dash = 1'b1;
          enter_zone(SEC_PRE);
        end else if (c == CH_PLUS) begin
          finish_core();
          enter_zone(SEC_BUILD);
        end else begin
          core_char(c);
          bump_len();
        end
      end
      SEC_PRE: begin
        if (c == CH_PLUS) begin
          finish_ident(SEC_PRE);
          enter_zone(SEC_BUILD);
        end else begin
          ident_char(SEC_PRE, c);
          bump_len();
        end
      end
      default: begin
        // '-' inside build metadata is only legal after a prerelease
        if (c == CH_DASH && !saw_dash) order_bad = 1'b1;
        ident_char(SEC_BUILD, c);
        bump_len();
      end
    endcase
    if (!last) return 1'b0;
    if (zone == SEC_CORE) finish_core();
    else finish_ident(zone);
    if (order_bad) code = ERR_ORDER;
    else if (zone_err[SEC_BUILD] != ERR_OK) code = zone_err[SEC_BUILD];
    else if (zone_err[SEC_PRE] != ERR_OK) code = zone_err[SEC_PRE];
    else code = zone_err[SEC_CORE];
    v.ok = code == ERR_OK;
    v.error_code = code;
    if (v.ok) begin
      v.major_value = core_nums[0];
      v.minor_value = core_nums[1];
      v.patch_value = core_nums[2];
    end
    v.has_pre = v.ok && saw_dash;
    v.has_meta = v.ok && zone == SEC_BUILD;
    clear_scan();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Verdict side
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : verdict_check
    int      stall;
    result_t want, got;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_gaps = !sink_gaps;
      stall = sink_gaps ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = result_t'(m_tdata[66:0]);
      if (verdict_q.size() == 0) begin
        $error("verdict item with none expected: error_code %0d", got.error_code);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("ok", want.ok, got.ok);
        check_field("error_code", want.error_code, got.error_code);
        check_field("major_value", want.major_value, got.major_value);
        check_field("minor_value", want.minor_value, got.minor_value);
        check_field("patch_value", want.patch_value, got.patch_value);
        check_field("has_pre", want.has_pre, got.has_pre);
        check_field("has_meta", want.has_meta, got.has_meta);
        check_field("fill", 0, m_tdata[71:67]);
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic last);
    int      gap;
    result_t v;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (predict_byte(c, last, v)) verdict_q.push_back(v);
    @(negedge clk);
  endtask

  task automatic send_line();
    src_gaps = $urandom_range(0, 3) != 0;
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  function automatic void put_byte(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_rep(logic [7:0] c, int n);
    for (int i = 0; i < n; i++) put_byte(c);
  endfunction

  // n bytes of "a.a.a..."
  function automatic void put_dotted(int n);
    for (int i = 0; i < n; i++) put_byte((i % 2) ? CH_DOT : CH_LOWER_A);
  endfunction

  function automatic void put_word(int n);
    for (int i = 0; i < n; i++) put_byte(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return punct_chars[$urandom_range(0, punct_chars.len() - 1)];
  endfunction

  task automatic send_str(string s);
    put_str(s);
    send_line();
  endtask

  function automatic void put_part();
    case ($urandom_range(0, 15))
      0: ;
      1: put_str($sformatf("0%0d", $urandom_range(0, 99)));
      2: put_str("1000000");
      3: put_str($sformatf("%0d", $urandom_range(1000001, 99999999)));
      4: put_word($urandom_range(1, 3));
      5, 6: put_str($sformatf("%0d", $urandom_range(0, 1000000)));
      default: put_str($sformatf("%0d", $urandom_range(0, 99)));
    endcase
  endfunction

  function automatic void put_idents();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_byte(CH_DOT);
      case ($urandom_range(0, 19))
        0: ;
        1: put_word($urandom_range(SEGMENT_MAX - 4, SEGMENT_MAX + 2));
        2, 3: put_str($sformatf("0%0d", $urandom_range(0, 99)));
        4, 5, 6: put_str($sformatf("%0d", $urandom_range(0, 9999)));
        default: put_word($urandom_range(1, 8));
      endcase
    end
  endfunction

  function automatic void put_version();
    if ($urandom_range(0, 3) == 0) put_byte($urandom_range(0, 1) ? CH_LOWER_V : CH_UPPER_V);
    for (int k = 0; k < 3; k++) begin
      if (k > 0) put_byte(CH_DOT);
      put_part();
    end
    if ($urandom_range(0, 1)) begin
      put_byte(CH_DASH);
      put_idents();
    end
    if ($urandom_range(0, 2) == 0) begin
      put_byte(CH_PLUS);
      put_idents();
    end
    if ($urandom_range(0, 7) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = noise_byte();
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_core_numbers();
    send_str("0.0.0");
    send_str("1.2.3");
    send_str("1000000.1000000.1000000");
    send_str("v1.2.3");
    send_str("V524288.999999.65535");
    send_str("1.2");
    send_str("1.2.3.4.5");
    send_str("1..3");
    send_str("1.2.");
    send_str("01.2.3");
    send_str("1.2.1000001");
    send_str("1.2.99999999999");
    send_str("1.a.3");
    send_str("-1.2.3");
    send_str("5");
    send_str("vv1.2.3");
  endtask

  task automatic test_prerelease_build();
    send_str("V0.1.0-alpha.1+build.5");
    send_str("1.2.3-0.3.7");
    send_str("1.2.3-rc-1+b-1");
    send_str("1.2.3+meta-data");
    send_str("1.2.3-");
    send_str("1.2.3+");
    send_str("1.2.3-01");
    send_str("1.2.3+01");
    send_str("1.2.3-a..b");
    send_str("1.2.3+a_b");
    send_str("1.2.3-a.+b");
  endtask

  task automatic test_special_bytes();
    // lone prefix, zero byte in the core, top byte value in the build
    send_str("v");
    send_str("V");
    put_str("1.2.");
    put_byte(8'h00);
    send_line();
    put_str("1.0.0+");
    put_byte(8'hFF);
    send_line();
  endtask

  task automatic test_length_limits();
    put_str("1.2.");
    put_rep(CH_NINE, SECTION_MAX - 5);
    send_line();
    put_str("1.2.");
    put_rep(CH_NINE, SECTION_MAX - 4);
    send_line();
    put_str("1.0.0-");
    put_rep(CH_UPPER_Z, SEGMENT_MAX - 1);
    send_line();
    put_str("1.0.0-");
    put_rep(CH_UPPER_Z, SEGMENT_MAX);
    send_line();
    put_str("1.0.0+");
    put_rep(CH_LOWER_Z, SEGMENT_MAX);
    send_line();
    put_str("1.0.0-");
    put_dotted(SECTION_MAX - 1);
    send_line();
    put_str("1.0.0-");
    put_dotted(SECTION_MAX);
    send_line();
    put_str("1.0.0+");
    put_dotted(SECTION_MAX);
    send_line();
  endtask

  task automatic test_random_versions();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int i = $urandom_range(1, 10); i > 0; i--) put_byte(noise_byte());
      end else begin
        put_version();
      end
      sent += line_buf.size();
      send_line();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    clear_scan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_core_numbers();
    test_prerelease_build();
    test_special_bytes();
    test_length_limits();
    test_random_versions();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog: roughly 2000 bytes need far less time than this limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
design/svv_pkg.sv
design/svv_in_reg.sv
design/svv_scan.sv
design/semver_string_validator.sv
sim/testbench.sv
